// ===== hw/rtl/sfpd_pkg.sv =====
// Shared types and constants of the suffix fractional power detector.
package sfpd_pkg;

    localparam int DEF_MAX_LEN = 256;

    // Input command codes (carried on s_tuser)
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Configuration register indexes (paddr[3:2])
    localparam int          CFG_ADDR_W = 4;
    localparam logic [1:0]  REG_NUM    = 2'd0;
    localparam logic [1:0]  REG_DEN    = 2'd1;
    localparam logic [1:0]  REG_STRICT = 2'd2;

    localparam logic [7:0]  RST_NUM    = 8'd2;
    localparam logic [7:0]  RST_DEN    = 8'd1;
    localparam logic        RST_STRICT = 1'b0;

    // Result item layout on m_tdata
    localparam int OUT_LEN_W  = 9;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic [7:0] num;
        logic [7:0] den;
        logic       strict_mode;
    } cfg_t;

    // Sequencer to period-test unit
    typedef struct packed {
        logic start;
        logic issue;
        logic first;
        logic update;
    } scan_ctrl_t;

    // Period-test unit back to sequencer
    typedef struct packed {
        logic busy;
        logic hit;
    } scan_stat_t;

endpackage

// ===== hw/rtl/sfpd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sfpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/sfpd_cfg.sv =====
// APB configuration registers: threshold numerator, denominator, strict mode.
module sfpd_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sfpd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output sfpd_pkg::cfg_t                 cfg
);

    logic [7:0] num_reg;
    logic [7:0] den_reg;
    logic       strict_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg    <= sfpd_pkg::RST_NUM;
            den_reg    <= sfpd_pkg::RST_DEN;
            strict_reg <= sfpd_pkg::RST_STRICT;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                sfpd_pkg::REG_NUM:    num_reg    <= pwdata[7:0];
                sfpd_pkg::REG_DEN:    den_reg    <= pwdata[7:0];
                sfpd_pkg::REG_STRICT: strict_reg <= pwdata[0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            sfpd_pkg::REG_NUM:    prdata = {24'd0, num_reg};
            sfpd_pkg::REG_DEN:    prdata = {24'd0, den_reg};
            sfpd_pkg::REG_STRICT: prdata = {31'd0, strict_reg};
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg.num         = num_reg;
    assign cfg.den         = den_reg;
    assign cfg.strict_mode = strict_reg;

endmodule

// ===== hw/rtl/sfpd_period_unit.sv =====
// Shared period-test unit: run update, run*den multiply, threshold compare.
module sfpd_period_unit #(
    parameter int ADDR_W = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sfpd_pkg::scan_ctrl_t   ctrl,
    input  logic [ADDR_W-1:0]      p,
    input  logic [7:0]             last_sym,
    input  logic [7:0]             word_rd,
    input  logic [ADDR_W-1:0]      run_rd,
    input  sfpd_pkg::cfg_t         cfg,
    output logic                   run_we,
    output logic [ADDR_W-1:0]      run_waddr,
    output logic [ADDR_W-1:0]      run_wdata,
    output sfpd_pkg::scan_stat_t   stat
);

    localparam int PW = ADDR_W + 8;

    // Stage B: memory data back, update run of period p
    logic              b_valid_reg;
    logic              b_first_reg;
    logic              b_upd_reg;
    logic [ADDR_W-1:0] b_p_reg;
    logic [PW-1:0]     acc_num_reg;
    logic [PW-1:0]     acc_den_reg;
    // Stage C: multiply
    logic              c_valid_reg;
    logic [ADDR_W-1:0] c_run_reg;
    logic [PW-1:0]     c_pnum_reg;
    logic [PW-1:0]     c_pden_reg;
    // Stage D: add and compare
    logic              d_valid_reg;
    logic              d_nz_reg;
    logic [PW-1:0]     d_prod_reg;
    logic [PW-1:0]     d_pnum_reg;
    logic [PW-1:0]     d_pden_reg;
    logic              hit_reg;

    logic              match;
    logic [ADDR_W-1:0] run_new;
    logic [PW-1:0]     pnum_cur;
    logic [PW-1:0]     pden_cur;
    logic [PW:0]       lhs;
    logic [PW:0]       rhs;
    logic              reach;

    assign match    = (word_rd == last_sym);
    assign pnum_cur = acc_num_reg + PW'(cfg.num);
    assign pden_cur = acc_den_reg + PW'(cfg.den);

    always_comb
    begin
        if (!b_upd_reg)
        begin
            run_new = run_rd;
        end
        else if (!match)
        begin
            run_new = '0;
        end
        else if (b_first_reg)
        begin
            run_new = ADDR_W'(1);
        end
        else
        begin
            run_new = run_rd + ADDR_W'(1);
        end
    end

    assign run_we    = b_valid_reg & b_upd_reg;
    assign run_waddr = b_p_reg;
    assign run_wdata = run_new;

    // L*den = p*den + run*den, compared against p*num
    assign lhs   = {1'b0, d_pden_reg} + {1'b0, d_prod_reg};
    assign rhs   = {1'b0, d_pnum_reg};
    assign reach = cfg.strict_mode ? (lhs > rhs) : (lhs >= rhs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            b_valid_reg <= ctrl.issue;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            if (ctrl.start)
            begin
                hit_reg <= 1'b0;
            end
            else if (d_valid_reg && d_nz_reg && reach)
            begin
                hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        b_first_reg <= ctrl.first;
        b_upd_reg   <= ctrl.update;
        b_p_reg     <= p;
        // Periods arrive in ascending order from 1, so p*num and p*den accumulate
        if (ctrl.start)
        begin
            acc_num_reg <= '0;
            acc_den_reg <= '0;
        end
        else if (b_valid_reg)
        begin
            acc_num_reg <= pnum_cur;
            acc_den_reg <= pden_cur;
        end
        c_run_reg  <= run_new;
        c_pnum_reg <= pnum_cur;
        c_pden_reg <= pden_cur;
        d_nz_reg   <= (c_run_reg != '0);
        d_prod_reg <= PW'(c_run_reg) * PW'(cfg.den);
        d_pnum_reg <= c_pnum_reg;
        d_pden_reg <= c_pden_reg;
    end

    assign stat.busy = b_valid_reg | c_valid_reg | d_valid_reg;
    assign stat.hit  = hit_reg;

endmodule

// ===== hw/rtl/sfpd_seq.sv =====
// Sequencer: word length, period counter, memory addressing and result register.
module sfpd_seq #(
    parameter int MAX_LEN = sfpd_pkg::DEF_MAX_LEN,
    parameter int LEN_W   = $clog2(MAX_LEN + 1),
    parameter int ADDR_W  = $clog2(MAX_LEN)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  logic [7:0]           symbol,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_hit,
    output logic [LEN_W-1:0]     out_len,
    output logic                 out_ovf,
    output logic                 word_we,
    output logic [ADDR_W-1:0]    word_waddr,
    output logic [ADDR_W-1:0]    word_raddr,
    output logic [ADDR_W-1:0]    p,
    output logic [7:0]           last_sym,
    output sfpd_pkg::scan_ctrl_t ctrl,
    input  sfpd_pkg::scan_stat_t stat
);

    localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_LEN);
    localparam logic [LEN_W-1:0] ONE      = LEN_W'(1);

    sfpd_pkg::seq_state_t state_reg;
    sfpd_pkg::seq_state_t state_next;

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] p_reg;
    logic             ovf_reg;
    logic             upd_reg;
    logic [7:0]       last_sym_reg;
    logic             out_valid_reg;
    logic             out_hit_reg;
    logic [LEN_W-1:0] out_len_reg;
    logic             out_ovf_reg;

    logic             accept;
    logic             is_clear;
    logic             is_full;
    logic             last_p;
    logic             load_out;
    logic [LEN_W-1:0] rd_index;

    assign accept   = in_valid & in_ready;
    assign is_clear = (cmd == sfpd_pkg::CMD_CLEAR);
    assign is_full  = (len_reg == FULL_LEN);
    assign last_p   = (p_reg == len_reg - ONE);
    assign rd_index = len_reg - ONE - p_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sfpd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_clear)
                    begin
                        state_next = sfpd_pkg::ST_DONE;
                    end
                    else if (is_full || len_reg != '0)
                    begin
                        state_next = sfpd_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = sfpd_pkg::ST_DONE;
                    end
                end
            end
            sfpd_pkg::ST_SCAN:
            begin
                if (last_p)
                begin
                    state_next = sfpd_pkg::ST_DRAIN;
                end
            end
            sfpd_pkg::ST_DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = sfpd_pkg::ST_DONE;
                end
            end
            sfpd_pkg::ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = sfpd_pkg::ST_IDLE;
                end
            end
            default: state_next = sfpd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        load_out    = 1'b0;
        ctrl.start  = 1'b0;
        ctrl.issue  = 1'b0;
        ctrl.first  = last_p;
        ctrl.update = upd_reg;
        unique case (state_reg)
            sfpd_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                ctrl.start = in_valid;
            end
            sfpd_pkg::ST_SCAN:
            begin
                ctrl.issue = 1'b1;
            end
            sfpd_pkg::ST_DRAIN:
            begin
            end
            sfpd_pkg::ST_DONE:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sfpd_pkg::ST_IDLE;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            upd_reg       <= 1'b0;
            p_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                p_reg <= ONE;
                if (is_clear)
                begin
                    len_reg <= '0;
                    ovf_reg <= 1'b0;
                    upd_reg <= 1'b0;
                end
                else if (is_full)
                begin
                    // Drop the symbol, retest the unchanged word
                    ovf_reg <= 1'b1;
                    upd_reg <= 1'b0;
                end
                else
                begin
                    len_reg <= len_reg + ONE;
                    ovf_reg <= 1'b0;
                    upd_reg <= 1'b1;
                end
            end
            else if (state_reg == sfpd_pkg::ST_SCAN)
            begin
                p_reg <= p_reg + ONE;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            last_sym_reg <= symbol;
        end
        if (load_out)
        begin
            out_hit_reg <= stat.hit;
            out_len_reg <= len_reg;
            out_ovf_reg <= ovf_reg;
        end
    end

    assign word_we    = accept & !is_clear & !is_full;
    assign word_waddr = len_reg[ADDR_W-1:0];
    assign word_raddr = rd_index[ADDR_W-1:0];
    assign p          = p_reg[ADDR_W-1:0];
    assign last_sym   = last_sym_reg;
    assign out_valid  = out_valid_reg;
    assign out_hit    = out_hit_reg;
    assign out_len    = out_len_reg;
    assign out_ovf    = out_ovf_reg;

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sfpd_pkg::ST_SCAN |-> p_reg != '0 && p_reg < len_reg)
        else $error("period counter outside the word during scan");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_ovf_reg |-> out_len_reg == FULL_LEN)
        else $error("dropped append reported with a store that is not full");

    a_short_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_len_reg < LEN_W'(2) |-> !out_hit_reg)
        else $error("hit reported on a word shorter than two symbols");

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == sfpd_pkg::ST_DONE))
        else $error("result loaded outside the done state");

endmodule

// ===== hw/rtl/suffix_fractional_power_detector_unit.sv =====
// Top level of the suffix fractional power detector.
//
// Each input item either clears the stored word (s_tuser = 1) or appends the symbol in
// s_tdata and reports whether the word now ends in a repetition of exponent at least
// (or, in strict mode, above) exponent_num/exponent_den. The run length of every period
// p is kept in a run memory and updated incrementally, one period per cycle through a
// single run-update, multiply and compare unit fed by one read port of the word memory.
// An append to a word of n symbols (n >= 1) tests periods 1..n: the item is accepted,
// the periods are scanned, the read, multiply and compare stages drain, and the result
// register is loaded, after which the block is ready again. A clear, or an append to an
// empty word, skips the scan and loads the result directly. A dropped append to a full
// store rechecks all MAX_LEN - 1 periods. This flow holds while the result register is
// free; a result still waiting holds the block before its next item. The block accepts
// one item at a time; the result register lets the next item be accepted while the
// previous result waits. No clearing pass is needed.
module suffix_fractional_power_detector_unit #(
    parameter int MAX_LEN = sfpd_pkg::DEF_MAX_LEN
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input item
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] symbol
    input  logic                            s_tuser,   // [0] cmd
    // Result item
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sfpd_pkg::OUT_DATA_W-1:0] m_tdata,   // [0] hit, [9:1] word_len, [10] overflow
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sfpd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);

    sfpd_pkg::cfg_t       cfg;
    sfpd_pkg::scan_ctrl_t ctrl;
    sfpd_pkg::scan_stat_t stat;

    logic              word_we;
    logic [ADDR_W-1:0] word_waddr;
    logic [ADDR_W-1:0] word_raddr;
    logic [7:0]        word_rd;
    logic [ADDR_W-1:0] p;
    logic [7:0]        last_sym;
    logic              run_we;
    logic [ADDR_W-1:0] run_waddr;
    logic [ADDR_W-1:0] run_wdata;
    logic [ADDR_W-1:0] run_rd;
    logic              out_hit;
    logic [LEN_W-1:0]  out_len;
    logic              out_ovf;

    sfpd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfpd_seq #(
        .MAX_LEN (MAX_LEN),
        .LEN_W   (LEN_W),
        .ADDR_W  (ADDR_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .cmd        (s_tuser),
        .symbol     (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_hit    (out_hit),
        .out_len    (out_len),
        .out_ovf    (out_ovf),
        .word_we    (word_we),
        .word_waddr (word_waddr),
        .word_raddr (word_raddr),
        .p          (p),
        .last_sym   (last_sym),
        .ctrl       (ctrl),
        .stat       (stat)
    );

    sfpd_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_word_ram (
        .clk   (clk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (s_tdata),
        .raddr (word_raddr),
        .rdata (word_rd)
    );

    sfpd_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_LEN)
    ) u_run_ram (
        .clk   (clk),
        .we    (run_we),
        .waddr (run_waddr),
        .wdata (run_wdata),
        .raddr (p),
        .rdata (run_rd)
    );

    sfpd_period_unit #(
        .ADDR_W (ADDR_W)
    ) u_period (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .p         (p),
        .last_sym  (last_sym),
        .word_rd   (word_rd),
        .run_rd    (run_rd),
        .cfg       (cfg),
        .run_we    (run_we),
        .run_waddr (run_waddr),
        .run_wdata (run_wdata),
        .stat      (stat)
    );

    assign m_tdata = {5'd0, out_ovf, sfpd_pkg::OUT_LEN_W'(out_len), out_hit};

endmodule

// ===== verif/tb_suffix_fractional_power_detector_unit.sv =====
// Testbench for the suffix fractional power detector: stream stimulus, threshold sweep, checks.
module tb_suffix_fractional_power_detector_unit;

    localparam int STORE_DEPTH = sfpd_pkg::DEF_MAX_LEN;
    localparam int DRAIN_CYCLES = STORE_DEPTH + 40;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int LONG_STALL_CYCLES = 400;

    typedef struct packed {
        logic       cmd;
        logic [7:0] sym;
    } word_op_t;

    typedef struct packed {
        logic       hit;
        logic [8:0] word_len;
        logic       overflow;
    } detect_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [sfpd_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [sfpd_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]                     pwdata = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    // Predictor state: word held by the block and the current threshold
    logic [7:0] word_mem [STORE_DEPTH];
    int         word_count;
    logic [7:0] thr_num;
    logic [7:0] thr_den;
    logic       thr_strict;

    word_op_t       pending_ops[$];
    detect_result_t expected_results[$];

    int  ops_queued;
    int  results_seen;
    int  err_count;
    int  cycle_count;
    int  n_appends;
    int  n_clears;
    int  n_hits;
    int  n_dropped;
    int  n_settings;
    int  gap_left;
    int  stall_left;
    bit  idle_on;
    bit  long_stall_req;

    suffix_fractional_power_detector_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Search every period shorter than the word for a long enough periodic suffix
    function automatic logic suffix_power_hit();
        int  n;
        int  p;
        int  run;
        longint lhs;
        longint rhs;
        n = word_count;
        for (p = 1; p < n; p++)
        begin
            run = 0;
            while (run < n - p && word_mem[n - 1 - run] == word_mem[n - 1 - run - p])
                run++;
            if (run >= 1)
            begin
                lhs = longint'(p + run) * longint'(thr_den);
                rhs = longint'(p) * longint'(thr_num);
                if (thr_strict ? (lhs > rhs) : (lhs >= rhs))
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic detect_result_t apply_word_op(logic cmd, logic [7:0] sym);
        detect_result_t r;
        r = '0;
        if (cmd == sfpd_pkg::CMD_CLEAR)
        begin
            word_count = 0;
            n_clears++;
        end
        else
        begin
            n_appends++;
            if (word_count < STORE_DEPTH)
            begin
                word_mem[word_count] = sym;
                word_count++;
            end
            else
            begin
                r.overflow = 1'b1;
                n_dropped++;
            end
            r.hit = suffix_power_hit();
            if (r.hit)
                n_hits++;
        end
        r.word_len = word_count[8:0];
        return r;
    endfunction

    // Driver: present the next pending item, predict its result on acceptance
    always @(posedge clk)
    begin
        detect_result_t r;
        word_op_t       nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                r = apply_word_op(s_tuser, s_tdata);
                expected_results.insert(expected_results.size(), r);
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_ops.size() == 0)
                    s_tvalid <= 1'b0;
                else if (idle_on && $urandom_range(0, 5) == 0)
                begin
                    gap_left = $urandom_range(0, 6);
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    nxt = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.sym;
                    s_tuser  <= nxt.cmd;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction, drive back-pressure
    always @(posedge clk)
    begin
        detect_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result with no item pending: m_tdata=%h", m_tdata);
                    err_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[0] !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, m_tdata[0]);
                        err_count++;
                    end
                    if (m_tdata[9:1] !== want.word_len)
                    begin
                        $error("word_len: expected %0d, got %0d", want.word_len, m_tdata[9:1]);
                        err_count++;
                    end
                    if (m_tdata[10] !== want.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d", want.overflow, m_tdata[10]);
                        err_count++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                stall_left = LONG_STALL_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    task automatic queue_op(logic cmd, logic [7:0] sym);
        word_op_t op;
        op.cmd = cmd;
        op.sym = sym;
        pending_ops.insert(pending_ops.size(), op);
        ops_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen < ops_queued)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sfpd_pkg::REG_NUM:    thr_num = val;
            sfpd_pkg::REG_DEN:    thr_den = val;
            sfpd_pkg::REG_STRICT: thr_strict = val[0];
            default:              ;
        endcase
    endtask

    // Drain the block, then load a new threshold
    task automatic set_threshold(logic [7:0] num, logic [7:0] den, logic strict);
        wait_drained();
        write_reg(sfpd_pkg::REG_NUM, num);
        write_reg(sfpd_pkg::REG_DEN, den);
        write_reg(sfpd_pkg::REG_STRICT, {7'b0, strict});
        n_settings++;
    endtask

    // Periodic words over small alphabets in half the groups, some free words and raw noise
    task automatic queue_mixed(int count);
        int         target;
        int         kind;
        int         len;
        int         per;
        int         k;
        int         nlet;
        logic [7:0] letters [4];
        logic [7:0] motif [6];
        target = ops_queued + count;
        while (ops_queued < target)
        begin
            kind = $urandom_range(0, 9);
            nlet = $urandom_range(1, 4);
            for (k = 0; k < 4; k++)
                letters[k] = 8'($urandom_range(0, 255));
            if (kind < 5)
            begin
                per = $urandom_range(1, 6);
                len = $urandom_range(per, 24);
                for (k = 0; k < per; k++)
                    motif[k] = letters[$urandom_range(0, nlet - 1)];
                queue_op(sfpd_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
                for (k = 0; k < len; k++)
                    queue_op(sfpd_pkg::CMD_APPEND, motif[k % per]);
                // break the pattern on the last letter now and then
                if ($urandom_range(0, 2) == 0)
                    queue_op(sfpd_pkg::CMD_APPEND, 8'($urandom_range(0, 255)));
            end
            else if (kind < 8)
            begin
                len = $urandom_range(1, 20);
                queue_op(sfpd_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
                for (k = 0; k < len; k++)
                    queue_op(sfpd_pkg::CMD_APPEND, letters[$urandom_range(0, nlet - 1)]);
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++)
                    queue_op(($urandom_range(0, 4) == 0) ? sfpd_pkg::CMD_CLEAR
                                                         : sfpd_pkg::CMD_APPEND,
                             8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Fill the store past its end so that appends are dropped
    task automatic queue_fill(int extra);
        int         k;
        logic [7:0] letters [3];
        for (k = 0; k < 3; k++)
            letters[k] = 8'($urandom_range(0, 255));
        queue_op(sfpd_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
        for (k = 0; k < STORE_DEPTH + extra; k++)
            queue_op(sfpd_pkg::CMD_APPEND, letters[$urandom_range(0, 2)]);
    endtask

    initial
    begin
        thr_num    = sfpd_pkg::RST_NUM;
        thr_den    = sfpd_pkg::RST_DEN;
        thr_strict = sfpd_pkg::RST_STRICT;
        word_count = 0;
        idle_on    = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset threshold
        queue_op(sfpd_pkg::CMD_CLEAR, 8'hFF);
        queue_op(sfpd_pkg::CMD_APPEND, 8'h00);
        queue_op(sfpd_pkg::CMD_APPEND, 8'h00);
        queue_op(sfpd_pkg::CMD_APPEND, 8'hFF);
        queue_op(sfpd_pkg::CMD_APPEND, 8'hFF);
        queue_op(sfpd_pkg::CMD_CLEAR, 8'h00);
        queue_op(sfpd_pkg::CMD_APPEND, 8'h5A);
        queue_op(sfpd_pkg::CMD_APPEND, 8'hA5);
        queue_op(sfpd_pkg::CMD_APPEND, 8'h5A);
        queue_op(sfpd_pkg::CMD_APPEND, 8'hA5);
        queue_op(sfpd_pkg::CMD_APPEND, 8'h5A);
        queue_op(sfpd_pkg::CMD_CLEAR, 8'h33);
        queue_op(sfpd_pkg::CMD_CLEAR, 8'hCC);
        queue_op(sfpd_pkg::CMD_APPEND, 8'h80);
        queue_op(sfpd_pkg::CMD_APPEND, 8'h01);
        queue_op(sfpd_pkg::CMD_APPEND, 8'h80);
        queue_op(sfpd_pkg::CMD_APPEND, 8'h7F);
        queue_op(sfpd_pkg::CMD_CLEAR, 8'h00);
        queue_op(sfpd_pkg::CMD_APPEND, 8'hFE);
        n_settings = 1;

        // Strict mode with a long receiver stall while the sender keeps offering
        set_threshold(8'd2, 8'd1, 1'b1);
        long_stall_req = 1'b1;
        queue_mixed(100);

        set_threshold(8'd3, 8'd2, 1'b0);
        queue_mixed(80);

        set_threshold(8'd1, 8'd1, 1'b0);
        queue_mixed(60);

        set_threshold(8'd5, 8'd2, 1'b0);
        queue_fill(6);
        queue_mixed(20);

        set_threshold(8'd1, 8'd255, 1'b1);
        queue_mixed(60);

        set_threshold(8'd255, 8'd255, 1'b1);
        queue_mixed(60);

        set_threshold(8'd255, 8'd1, 1'b0);
        queue_mixed(30);

        set_threshold(8'd0, 8'd7, 1'b0);
        queue_mixed(30);

        set_threshold(8'd9, 8'd0, 1'b1);
        queue_mixed(30);

        repeat (3)
        begin
            set_threshold(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                          1'($urandom_range(0, 1)));
            queue_mixed(50);
        end

        // Closing stretch at full rate on both sides
        set_threshold(8'd2, 8'd1, 1'b0);
        idle_on = 1'b0;
        queue_mixed(80);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", expected_results.size());
            err_count++;
        end
        $display("Covered %0d appends and %0d clears over %0d threshold settings,",
                 n_appends, n_clears, n_settings);
        $display("with %0d repetition hits and %0d appends dropped at a full store.",
                 n_hits, n_dropped);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
